// File: hdl/scsi_command_queue_assert.svh
// assertion macros shared by the command queue modules
`ifndef SCSI_COMMAND_QUEUE_ASSERT_SVH
`define SCSI_COMMAND_QUEUE_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define SCQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scq assertion failed");

// next-cycle implication, checked only out of reset
`define SCQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scq assertion failed");

`endif

// File: hdl/scq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scq_pkg;

    // pool size and stored handle width
    localparam int QUEUE_DEPTH = 32;
    localparam int HANDLE_BITS = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - 17;

    localparam logic [7:0] OPC_REQUEST_SENSE = 8'h03;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;

    typedef enum logic [2:0] {
        FN_ADD_TAIL      = 3'd0,
        FN_ADD_ORDERED   = 3'd1,
        FN_REMOVE_HEAD   = 3'd2,
        FN_REMOVE_IDLE   = 3'd3,
        FN_REMOVE_TLT    = 3'd4,
        FN_PROBE_TL      = 3'd5,
        FN_FIND_HANDLE   = 3'd6,
        FN_REMOVE_HANDLE = 3'd7
    } func_t;

    // input item as packed on s_tdata, last field lowest
    typedef struct packed {
        logic [6:0]  pad;
        logic [63:0] busy_map;
        logic [7:0]  opcode_byte;
        logic [7:0]  tag_id;
        logic [2:0]  lun_id;
        logic [2:0]  target_id;
        logic [15:0] cmd_handle;
        func_t       func;
    } item_t;

    // one pool entry
    typedef struct packed {
        handle_t    handle;
        logic [2:0] target;
        logic [2:0] lun;
        logic [7:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_LINK,
        ST_ADD_TAIL,
        ST_WALK,
        ST_UNLINK_PREV,
        ST_UNLINK_FREE,
        ST_PASS,
        ST_FAIL
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic add_read;
        logic add_link;
        logic add_tail;
        logic walk_start;
        logic walk_step;
        logic walk_hit;
        logic unlink_prev;
        logic unlink_free;
        logic result_load;
        logic result_ok;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_add;
        logic full;
        logic empty;
        logic tail_link;
        logic remove_op;
        logic match;
        logic last_pos;
        logic out_free;
    } dp_status_t;

    // successor of a pool index, as chained after reset
    function automatic idx_t idx_succ(input idx_t i);
        idx_succ = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
    endfunction

endpackage

`default_nettype wire

// File: hdl/scq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module scq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/scq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "scsi_command_queue_assert.svh"

module scq_ctrl
    import scq_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  dp_status_t  status,
    output ctl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.is_add) begin
                    state_next = status.full ? ST_FAIL : ST_ADD_LINK;
                end else begin
                    state_next = status.empty ? ST_FAIL : ST_WALK;
                end
            end
            ST_ADD_LINK: begin
                state_next = status.tail_link ? ST_ADD_TAIL : ST_PASS;
            end
            ST_ADD_TAIL: begin
                state_next = ST_PASS;
            end
            ST_WALK: begin
                priority if (status.match) begin
                    state_next = status.remove_op ? ST_UNLINK_PREV : ST_PASS;
                end else if (status.last_pos) begin
                    state_next = ST_FAIL;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_UNLINK_PREV: begin
                state_next = ST_UNLINK_FREE;
            end
            ST_UNLINK_FREE: begin
                state_next = ST_PASS;
            end
            ST_PASS, ST_FAIL: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_DECODE: begin
                cmd.add_read   = status.is_add && !status.full;
                cmd.walk_start = !status.is_add && !status.empty;
            end
            ST_ADD_LINK: begin
                cmd.add_link = 1'b1;
            end
            ST_ADD_TAIL: begin
                cmd.add_tail = 1'b1;
            end
            ST_WALK: begin
                cmd.walk_hit  = status.match;
                cmd.walk_step = !status.match && !status.last_pos;
            end
            ST_UNLINK_PREV: begin
                cmd.unlink_prev = 1'b1;
            end
            ST_UNLINK_FREE: begin
                cmd.unlink_free = 1'b1;
            end
            ST_PASS: begin
                cmd.result_load = status.out_free;
                cmd.result_ok   = 1'b1;
            end
            ST_FAIL: begin
                cmd.result_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // checks
    `SCQ_ASSERT_IMP(a_link_not_full, aclk, aresetn, state_reg == ST_ADD_LINK, !status.full)
    `SCQ_ASSERT_IMP(a_walk_not_empty, aclk, aresetn, state_reg == ST_WALK, !status.empty)
    `SCQ_ASSERT_NXT(a_tail_after_link, aclk, aresetn, state_reg == ST_ADD_TAIL, state_reg == ST_PASS)

endmodule

`default_nettype wire

// File: hdl/scq_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "scsi_command_queue_assert.svh"

module scq_dpath
    import scq_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire  [S_TDATA_W-1:0] s_tdata,
    input  ctl_cmd_t             cmd,
    output dp_status_t           status,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    // latched item
    item_t   item_reg;
    func_t   func;
    entry_t  new_entry;

    // list pointers
    idx_t    head_reg;
    idx_t    tail_reg;
    idx_t    free_reg;
    cnt_t    count_reg;
    logic [QUEUE_DEPTH-1:0] nvalid_reg;

    // walk state
    idx_t    q_reg;
    idx_t    pr_reg;
    cnt_t    pos_reg;
    idx_t    nx_reg;
    idx_t    rd_addr_reg;
    handle_t hit_handle_reg;

    // result register
    logic        m_tvalid_reg;
    logic        m_ok_reg;
    logic [15:0] m_handle_reg;

    // ram ports
    idx_t    ram_raddr;
    logic    next_we;
    idx_t    next_waddr;
    idx_t    next_wdata;
    idx_t    next_rdata;
    entry_t  pay_rdata;
    idx_t    nx_rd;

    logic    head_op;
    logic    first_pos;
    logic    busy_bit;
    logic    entry_match;

    assign func = item_reg.func;

    assign new_entry.handle = HANDLE_BITS'(item_reg.cmd_handle);
    assign new_entry.target = item_reg.target_id;
    assign new_entry.lun    = item_reg.lun_id;
    assign new_entry.tag    = item_reg.tag_id;

    // item capture on input transfer
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= item_t'(s_tdata);
        end
    end

    // successor read back from the link ram, reset chain where never written
    assign nx_rd = nvalid_reg[rd_addr_reg] ? next_rdata : idx_succ(rd_addr_reg);

    // an ordered add of request sense goes in front when the queue is not empty
    assign head_op = (func == FN_ADD_ORDERED) && (item_reg.opcode_byte == OPC_REQUEST_SENSE);

    assign first_pos = (pos_reg == '0);
    assign busy_bit  = item_reg.busy_map[{pay_rdata.target, pay_rdata.lun}];

    // entry compare by operation
    always_comb begin
        unique case (func)
            FN_ADD_TAIL, FN_ADD_ORDERED: entry_match = 1'b0;
            FN_REMOVE_HEAD:              entry_match = 1'b1;
            FN_REMOVE_IDLE:              entry_match = !busy_bit;
            FN_REMOVE_TLT: begin
                entry_match = (pay_rdata.target == item_reg.target_id)
                           && (pay_rdata.lun == item_reg.lun_id)
                           && (pay_rdata.tag == item_reg.tag_id);
            end
            FN_PROBE_TL: begin
                entry_match = (pay_rdata.target == item_reg.target_id)
                           && (pay_rdata.lun == item_reg.lun_id);
            end
            FN_FIND_HANDLE, FN_REMOVE_HANDLE: begin
                entry_match = (pay_rdata.handle == HANDLE_BITS'(item_reg.cmd_handle));
            end
            default: entry_match = 1'b0;
        endcase
    end

    // status to the controller
    assign status.is_add    = (func == FN_ADD_TAIL) || (func == FN_ADD_ORDERED);
    assign status.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty     = (count_reg == '0);
    assign status.tail_link = (count_reg != '0) && !head_op;
    assign status.remove_op = (func == FN_REMOVE_HEAD) || (func == FN_REMOVE_IDLE)
                           || (func == FN_REMOVE_TLT) || (func == FN_REMOVE_HANDLE);
    assign status.match     = entry_match;
    assign status.last_pos  = (CNT_W'(pos_reg + 1'b1) == count_reg);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // read address for both rams
    always_comb begin
        priority if (cmd.add_read) begin
            ram_raddr = free_reg;
        end else if (cmd.walk_start) begin
            ram_raddr = head_reg;
        end else if (cmd.walk_step) begin
            ram_raddr = nx_rd;
        end else begin
            ram_raddr = rd_addr_reg;
        end
    end

    // link ram write
    always_comb begin
        next_we    = 1'b0;
        next_waddr = free_reg;
        next_wdata = '0;
        priority if (cmd.add_link) begin
            next_we    = 1'b1;
            next_waddr = free_reg;
            next_wdata = (head_op && count_reg != '0) ? head_reg : '0;
        end else if (cmd.add_tail) begin
            next_we    = 1'b1;
            next_waddr = tail_reg;
            next_wdata = q_reg;
        end else if (cmd.unlink_prev) begin
            next_we    = !first_pos;
            next_waddr = pr_reg;
            next_wdata = nx_reg;
        end else if (cmd.unlink_free) begin
            next_we    = 1'b1;
            next_waddr = q_reg;
            next_wdata = free_reg;
        end else begin
            next_we    = 1'b0;
        end
    end

    scq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_pay_ram (
        .clk   (aclk),
        .we    (cmd.add_read),
        .waddr (free_reg),
        .wdata (new_entry),
        .raddr (ram_raddr),
        .rdata (pay_rdata)
    );

    scq_ram #(
        .WIDTH (IDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_next_ram (
        .clk   (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (ram_raddr),
        .rdata (next_rdata)
    );

    // list pointers, count and link valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            free_reg   <= '0;
            count_reg  <= '0;
            nvalid_reg <= '0;
        end else begin
            if (next_we) begin
                nvalid_reg[next_waddr] <= 1'b1;
            end
            if (cmd.add_link) begin
                free_reg  <= nx_rd;
                count_reg <= CNT_W'(count_reg + 1'b1);
                if (count_reg == '0) begin
                    head_reg <= free_reg;
                    tail_reg <= free_reg;
                end else if (head_op) begin
                    head_reg <= free_reg;
                end
            end
            if (cmd.add_tail) begin
                tail_reg <= q_reg;
            end
            if (cmd.unlink_prev) begin
                if (first_pos) begin
                    head_reg <= nx_reg;
                end else if (status.last_pos) begin
                    tail_reg <= pr_reg;
                end
            end
            if (cmd.unlink_free) begin
                free_reg  <= q_reg;
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

    // walk position and hit capture
    always_ff @(posedge aclk) begin
        rd_addr_reg <= ram_raddr;
        if (cmd.add_link) begin
            q_reg <= free_reg;
        end
        if (cmd.walk_start) begin
            q_reg   <= head_reg;
            pr_reg  <= '0;
            pos_reg <= '0;
        end
        if (cmd.walk_step) begin
            pr_reg  <= q_reg;
            q_reg   <= nx_rd;
            pos_reg <= CNT_W'(pos_reg + 1'b1);
        end
        if (cmd.walk_hit) begin
            nx_reg         <= nx_rd;
            hit_handle_reg <= pay_rdata.handle;
        end
    end

    // result register, valid cleared on output transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_ok_reg     <= cmd.result_ok;
            m_handle_reg <= (cmd.result_ok && status.remove_op) ? 16'(hit_handle_reg) : 16'h0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_handle_reg, m_ok_reg};

    // checks
    `SCQ_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `SCQ_ASSERT_NXT(a_add_counts, aclk, aresetn, cmd.add_link, count_reg == CNT_W'($past(count_reg) + 1'b1))
    `SCQ_ASSERT_NXT(a_walk_in_list, aclk, aresetn, cmd.walk_step, pos_reg < count_reg)

endmodule

`default_nettype wire

// File: hdl/scsi_command_queue.sv
// sequence: an add passes decode and link, plus a tail step when it links behind the tail;
// a full queue fails at decode; a search walks the list from the head, plus an unlink and a
// free step to remove; the walk follows one link per cycle through the registered link ram;
// a new item is taken only when idle, after the result of the last one is loaded
// reset: synchronous, active low; empties the queue, restores the free chain through
// per-entry link valid bits at once, no clearing pass; the entry ram is not cleared
`timescale 1ns / 1ps
`default_nettype none

module scsi_command_queue
    import scq_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // func, cmd_handle, target_id, lun_id, tag_id, opcode_byte, busy_map
    input  wire  [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // ok, out_handle
    output logic [M_TDATA_W-1:0] m_tdata
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    scq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    scq_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: test/scsi_command_queue_tb.sv
`timescale 1ns / 1ps

module scsi_command_queue_tb;
    import scq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 60;

    // completion seen on m_tdata, lowest bit first: ok, out_handle
    typedef struct packed {
        logic    ok;
        handle_t handle;
    } reply_t;

    // ordered list of queued commands plus the completions they owe
    class queue_scoreboard;
        entry_t cmd_list[$];
        reply_t replies_due[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        // position of the first queued command that the search hits, -1 if none
        function int find_match(item_t it);
            for (int i = 0; i < cmd_list.size(); i++) begin
                entry_t e;
                bit     hit;
                e = cmd_list[i];
                case (it.func)
                    FN_REMOVE_IDLE:   hit = !it.busy_map[{e.target, e.lun}];
                    FN_REMOVE_TLT:    hit = e.target == it.target_id && e.lun == it.lun_id
                                            && e.tag == it.tag_id;
                    FN_PROBE_TL:      hit = e.target == it.target_id && e.lun == it.lun_id;
                    FN_FIND_HANDLE,
                    FN_REMOVE_HANDLE: hit = e.handle == it.cmd_handle;
                    default:          hit = 1'b1;
                endcase
                if (hit) return i;
            end
            return -1;
        endfunction

        // update the list for an accepted command and queue its completion
        function void apply_command(item_t it);
            reply_t r;
            entry_t e;
            int     pos;
            r        = '0;
            e.handle = it.cmd_handle;
            e.target = it.target_id;
            e.lun    = it.lun_id;
            e.tag    = it.tag_id;
            case (it.func)
                FN_ADD_TAIL, FN_ADD_ORDERED: begin
                    if (cmd_list.size() < QUEUE_DEPTH) begin
                        r.ok = 1'b1;
                        // request sense jumps the queue
                        if (it.func == FN_ADD_ORDERED && it.opcode_byte == OPC_REQUEST_SENSE)
                            cmd_list.push_front(e);
                        else
                            cmd_list.push_back(e);
                    end
                end
                default: begin
                    pos = find_match(it);
                    if (pos >= 0) begin
                        r.ok = 1'b1;
                        if (it.func != FN_PROBE_TL && it.func != FN_FIND_HANDLE) begin
                            r.handle = cmd_list[pos].handle;
                            cmd_list.delete(pos);
                        end
                    end
                end
            endcase
            replies_due.push_back(r);
        endfunction

        // compare one completion transfer with the oldest one owed
        function void check_reply(logic [M_TDATA_W-1:0] d);
            reply_t got;
            reply_t want;
            got.ok     = d[0];
            got.handle = d[16:1];
            if (replies_due.size() == 0) begin
                $display("%0t: completion with none owed, ok=%0b handle=%h",
                         $time, got.ok, got.handle);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.ok !== want.ok) begin
                $display("%0t: ok mismatch, expected %0b actual %0b",
                         $time, want.ok, got.ok);
                errors++;
            end
            if (got.handle !== want.handle) begin
                $display("%0t: out_handle mismatch, expected %h actual %h",
                         $time, want.handle, got.handle);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    wire                  s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    wire  [M_TDATA_W-1:0] m_tdata;
    logic                 calm = 1'b0;
    int                   cycle_count;
    int                   add_pct[PHASES] = '{90, 50, 20, 60, 10, 70, 50, 30};

    queue_scoreboard scb = new();

    scsi_command_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // completion side: check each transfer, stall at random unless calm
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            scb.check_reply(m_tdata);
        m_tready <= calm || ($urandom_range(99) >= 25);
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // one command transfer, with an optional idle gap ahead of it
    task automatic send_item(input item_t it);
        if (!calm && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do @(posedge aclk); while (!s_tready);
        scb.apply_command(it);
    endtask

    task automatic send_fields(input func_t f, input handle_t h, input logic [2:0] t,
                               input logic [2:0] l, input logic [7:0] tag,
                               input logic [7:0] op, input logic [63:0] busy);
        item_t it;
        it             = '0;
        it.func        = f;
        it.cmd_handle  = h;
        it.target_id   = t;
        it.lun_id      = l;
        it.tag_id      = tag;
        it.opcode_byte = op;
        it.busy_map    = busy;
        send_item(it);
    endtask

    // random command, keys often taken from a queued command so searches hit
    task automatic make_item(input int pct, output item_t it);
        entry_t e;
        it             = '0;
        it.cmd_handle  = ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
        it.target_id   = 3'($urandom);
        it.lun_id      = 3'($urandom);
        it.tag_id      = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
        it.opcode_byte = ($urandom_range(1) == 0) ? OPC_REQUEST_SENSE : 8'($urandom);
        if (scb.cmd_list.size() > 0 && $urandom_range(99) < 65) begin
            e             = scb.cmd_list[$urandom_range(scb.cmd_list.size() - 1)];
            it.cmd_handle = e.handle;
            it.target_id  = e.target;
            it.lun_id     = e.lun;
            it.tag_id     = e.tag;
        end
        case ($urandom_range(3))
            0: it.busy_map = '0;
            1: it.busy_map = '1;
            2: it.busy_map = {$urandom, $urandom};
            default: begin
                // everything busy but the device of one command
                it.busy_map = '1;
                it.busy_map[{it.target_id, it.lun_id}] = 1'b0;
            end
        endcase
        if ($urandom_range(99) < pct)
            it.func = ($urandom_range(1) == 0) ? FN_ADD_TAIL : FN_ADD_ORDERED;
        else
            it.func = func_t'(3'($urandom_range(7, 2)));
    endtask

    // stimulus
    initial begin
        item_t it;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every search on an empty queue
        send_fields(FN_REMOVE_HEAD,   16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_PROBE_TL,      16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_FIND_HANDLE,   16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_REMOVE_HANDLE, 16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_REMOVE_IDLE,   16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_REMOVE_TLT,    16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        // field extremes, request sense to the head, other opcodes to the tail
        send_fields(FN_ADD_TAIL,    16'hFFFF, 3'd7, 3'd7, 8'hFF, 8'hFF, '1);
        send_fields(FN_ADD_TAIL,    16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_ADD_ORDERED, 16'h1234, 3'd3, 3'd5, 8'h5A, OPC_REQUEST_SENSE, '0);
        send_fields(FN_ADD_ORDERED, 16'hABCD, 3'd1, 3'd2, 8'hA5, 8'h02, '0);
        send_fields(FN_ADD_ORDERED, 16'h8001, 3'd7, 3'd7, 8'h01, 8'hFF, '0);
        // hits and misses of the handle, target-lun and tag searches
        send_fields(FN_FIND_HANDLE, 16'hFFFF, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_FIND_HANDLE, 16'h5555, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_PROBE_TL,    16'h0000, 3'd7, 3'd7, 8'h00, 8'h00, '0);
        send_fields(FN_PROBE_TL,    16'h0000, 3'd4, 3'd4, 8'h00, 8'h00, '0);
        send_fields(FN_REMOVE_TLT,  16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_REMOVE_TLT,  16'h0000, 3'd7, 3'd7, 8'h02, 8'h00, '0);
        // busy map: all busy, one device free, none busy
        send_fields(FN_REMOVE_IDLE, 16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '1);
        send_fields(FN_REMOVE_IDLE, 16'h0000, 3'd0, 3'd0, 8'h00, 8'h00,
                    64'h7FFF_FFFF_FFFF_FFFF);
        send_fields(FN_REMOVE_IDLE,   16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_REMOVE_HANDLE, 16'h8001, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_REMOVE_HANDLE, 16'h8001, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_REMOVE_HEAD,   16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);
        send_fields(FN_REMOVE_HEAD,   16'h0000, 3'd0, 3'd0, 8'h00, 8'h00, '0);

        // random phases: fill past full, mixed, drain to empty; one phase calm
        for (int ph = 0; ph < PHASES; ph++) begin
            calm <= (ph == 5);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                make_item(add_pct[ph], it);
                send_item(it);
            end
            // hold off until every completion has come back
            if (ph == 0 || ph == 4) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (scb.replies_due.size() != 0);
            end
        end

        s_tvalid <= 1'b0;
        calm     <= 1'b0;
        do @(posedge aclk); while (scb.replies_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scb.errors == 0 && scb.replies_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/scq_pkg.sv
hdl/scq_ram.sv
hdl/scq_ctrl.sv
hdl/scq_dpath.sv
hdl/scsi_command_queue.sv
test/scsi_command_queue_tb.sv
